>>> hdl/mcds_pkg.sv
`default_nettype none

package mcds_pkg;

   localparam int CHANNELS = 5;
   localparam int ACC_WIDTH = 32;

   localparam int OPCODE_WIDTH = 3;
   localparam int CHAN_WIDTH = 3;
   localparam int RATE_WIDTH = 32;
   localparam int MASK_BITS = 5;
   localparam int COUNT_WIDTH = 32;

   localparam logic [OPCODE_WIDTH-1:0] OP_TICK = 3'd0;
   localparam logic [OPCODE_WIDTH-1:0] OP_STAGE = 3'd1;
   localparam logic [OPCODE_WIDTH-1:0] OP_COMMIT = 3'd2;
   localparam logic [OPCODE_WIDTH-1:0] OP_CLEAR = 3'd3;
   localparam logic [OPCODE_WIDTH-1:0] OP_READ = 3'd4;

   // Command broadcast to every channel for one transaction.
   typedef struct packed {
      logic tick;
      logic stage;
      logic commit;
      logic clear;
      logic [ACC_WIDTH-1:0] staged_value;
   } chan_cmd_type;

endpackage

`default_nettype wire

>>> hdl/mcds_channel.sv
`default_nettype none

module mcds_channel
   import mcds_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire chan_cmd_type           cmd,
   input  wire logic                   select,
   output logic                        wrap,
   output logic [COUNT_WIDTH-1:0]      count
);

   logic [ACC_WIDTH-1:0]   phase_ff, phase_in;
   logic [ACC_WIDTH-1:0]   active_ff, active_in;
   logic [ACC_WIDTH-1:0]   staged_ff, staged_in;
   logic [COUNT_WIDTH-1:0] counter_ff, counter_in;
   logic [ACC_WIDTH:0]     sum;

   // A carry out of the add is exactly the case where the new phase is below the old.
   assign sum = {1'b0, phase_ff} + {1'b0, active_ff};
   assign wrap = cmd.tick & sum[ACC_WIDTH];
   assign count = counter_ff;

   always_comb begin
      phase_in = phase_ff;
      active_in = active_ff;
      staged_in = staged_ff;
      counter_in = counter_ff;
      if (cmd.tick) begin
         phase_in = sum[ACC_WIDTH-1:0];
         if (sum[ACC_WIDTH]) begin
            counter_in = counter_ff + COUNT_WIDTH'(1);
         end
      end
      if (cmd.stage && select) begin
         staged_in = cmd.staged_value;
      end
      if (cmd.commit) begin
         active_in = staged_ff;
      end
      if (cmd.clear) begin
         phase_in = '0;
         counter_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         active_ff <= '0;
         staged_ff <= '0;
         counter_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         active_ff <= active_in;
         staged_ff <= staged_in;
         counter_ff <= counter_in;
      end
   end

endmodule

`default_nettype wire

>>> hdl/multi_channel_dds_step_generator.sv
// Multi-channel DDS step-pulse generator.
// Input channel (req_*): one transaction carries an opcode, a channel index
// and a phase increment. Opcodes are tick, stage rate, commit rates, clear
// counts and phases, and read count. Every transaction yields exactly one
// transaction on the result channel (rsp_*): a step mask with one bit per
// wrapped channel on a tick, or a channel's step count on a read, else zero.
// The csr_ port writes the minimum increment; staged rates below it stop
// the channel. Write it only while no transaction is in flight.
// rsp_valid rises once an accepted transaction has passed the input register
// and then the result register, which loads as all channels update in
// parallel; a stalled result can hold it in the input register.
// One transaction is taken per cycle while results are taken; the
// accumulator add in each channel is combinational.
// If the receiver stalls, the result register holds its value and the input
// register still takes one more transaction; req_ready then drops until the
// result is taken.
// Synchronous reset clears both registers' valid flags, all phases,
// increments and step counters, and the minimum increment.
`default_nettype none

module multi_channel_dds_step_generator
   import mcds_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic [OPCODE_WIDTH-1:0]  req_opcode,
   input  wire logic [CHAN_WIDTH-1:0]    req_channel,
   input  wire logic [RATE_WIDTH-1:0]    req_rate_increment,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic [MASK_BITS-1:0]          rsp_step_mask,
   output logic [COUNT_WIDTH-1:0]        rsp_step_count,
   input  wire logic                     csr_write,
   input  wire logic [RATE_WIDTH-1:0]    csr_wdata
);

   logic                      in_valid_ff;
   logic [OPCODE_WIDTH-1:0]   opcode_ff;
   logic [CHAN_WIDTH-1:0]     channel_ff;
   logic [RATE_WIDTH-1:0]     rate_ff;
   logic [RATE_WIDTH-1:0]     min_increment_ff;
   logic                      out_valid_ff;
   logic [MASK_BITS-1:0]      mask_ff, mask_in;
   logic [COUNT_WIDTH-1:0]    count_ff, count_in;

   logic                      advance;
   logic                      is_read;
   chan_cmd_type              cmd;
   logic [ACC_WIDTH+RATE_WIDTH-1:0] rate_ext;
   logic [CHANNELS-1:0]       wrap;
   logic [CHANNELS-1:0]       select;
   logic [COUNT_WIDTH-1:0]    count [CHANNELS];
   logic [CHANNELS+MASK_BITS-1:0] wrap_ext;

   assign advance = in_valid_ff & (~out_valid_ff | rsp_ready);
   assign req_ready = ~in_valid_ff | advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_step_mask = mask_ff;
   assign rsp_step_count = count_ff;

   assign rate_ext = {{ACC_WIDTH{1'b0}}, rate_ff};

   always_comb begin
      cmd = '0;
      is_read = 1'b0;
      cmd.staged_value = (rate_ff < min_increment_ff) ? '0 : rate_ext[ACC_WIDTH-1:0];
      unique case (opcode_ff)
         OP_TICK:   cmd.tick = advance;
         OP_STAGE:  cmd.stage = advance;
         OP_COMMIT: cmd.commit = advance;
         OP_CLEAR:  cmd.clear = advance;
         OP_READ:   is_read = 1'b1;
         default:   ;
      endcase
   end

   for (genvar i = 0; i < CHANNELS; i++) begin : g_chan
      assign select[i] = (32'(channel_ff) == 32'(i));

      mcds_channel u_channel (
         .clock  (clock),
         .reset  (reset),
         .cmd    (cmd),
         .select (select[i]),
         .wrap   (wrap[i]),
         .count  (count[i])
      );
   end

   // Channels beyond the mask width still step but have no mask bit.
   assign wrap_ext = {{MASK_BITS{1'b0}}, wrap};

   always_comb begin
      mask_in = wrap_ext[MASK_BITS-1:0];
      count_in = '0;
      for (int i = 0; i < CHANNELS; i++) begin
         if (is_read && select[i]) begin
            count_in = count[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         min_increment_ff <= '0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
         if (csr_write) begin
            min_increment_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         opcode_ff <= req_opcode;
         channel_ff <= req_channel;
         rate_ff <= req_rate_increment;
      end
      if (advance) begin
         mask_ff <= mask_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

>>> hdl/mcds_checker.sv
`default_nettype none

module mcds_checker
   import mcds_pkg::*;
(
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_valid,
   input wire logic                     req_ready,
   input wire logic [OPCODE_WIDTH-1:0]  req_opcode,
   input wire logic [CHAN_WIDTH-1:0]    req_channel,
   input wire logic [RATE_WIDTH-1:0]    req_rate_increment,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_ready,
   input wire logic [MASK_BITS-1:0]     rsp_step_mask,
   input wire logic [COUNT_WIDTH-1:0]   rsp_step_count,
   input wire logic                     csr_write,
   input wire logic [RATE_WIDTH-1:0]    csr_wdata
);

   // A stalled result keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_step_mask) && $stable(rsp_step_count)))
      else $error("result changed while stalled");

   // A result is never both a step mask and a count.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_step_mask == '0 || rsp_step_count == '0))
      else $error("result carries both mask and count");

   // Reset leaves no result pending.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // With the result stalled and one transaction already buffered, input must stall.
   assert property (@(posedge clock) disable iff (reset)
      ($past(!reset && req_valid && req_ready && rsp_valid && !rsp_ready)
         && rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("input accepted with both registers full");

endmodule

bind multi_channel_dds_step_generator mcds_checker u_mcds_checker (.*);

`default_nettype wire
